### rtl/ball_wall_impulse_resolve_top_defines.svh
// Assertion macros for the disc and wall contact block.
// Used by ball_wall_impulse_resolve_top; depends on nothing else.
`ifndef BALL_WALL_IMPULSE_RESOLVE_TOP_DEFINES_SVH
`define BALL_WALL_IMPULSE_RESOLVE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BWIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwir assertion failed");
`define BWIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwir assertion failed");
`else
`define BWIR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BWIR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/bwir_pkg.sv
// Package for the disc and wall contact block: constants, register indexes, item types.
// Depends on nothing; used by bwir_wall and ball_wall_impulse_resolve_top.
`timescale 1ns / 1ps
package bwir_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 40;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_BOX_CX   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_CY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_W    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_H    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WALL_RST = 3'd4;

    localparam logic [16:0] RESTITUTION_RESET = 17'd52429;
    localparam logic [17:0] ONE_Q             = 18'(1 << FRAC_BITS);
    localparam logic [40:0] SPIN_CAP          = 41'h100_0000_0000;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_LOW  = 2'd1;
    localparam logic [1:0] HIT_HIGH = 2'd2;

    typedef struct packed {
        logic               asleep;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic [30:0]        radius;
        logic [30:0]        mass;
        logic [46:0]        inertia;
        logic [18:0]        friction;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_spin;
        logic [1:0]         side_wall_hit;
        logic [31:0]        side_impulse;
        logic [1:0]         floor_wall_hit;
        logic [31:0]        floor_impulse;
    } t_out_item;

    typedef struct packed {
        logic               asleep;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic [30:0]        radius;
        logic [30:0]        mass;
        logic [46:0]        inertia;
        logic [18:0]        friction;
        logic [45:0]        rm;
        logic [1:0]         side_hit;
        logic [31:0]        side_imp;
        logic [1:0]         floor_hit;
        logic [31:0]        floor_imp;
    } t_disc;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/bwir_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
// Depends on nothing; the payload type is set where it is instantiated.
`timescale 1ns / 1ps
interface bwir_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/bwir_wall.sv
// Pipelined contact resolution of one disc against one pair of opposite walls.
// Depends on bwir_pkg; instantiated twice by ball_wall_impulse_resolve_top.
`timescale 1ns / 1ps
module bwir_wall
    import bwir_pkg::*;
#(
    parameter bit FLOOR = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_disc              i_disc,
    input  logic signed [32:0] i_lo,
    input  logic signed [32:0] i_hi,
    input  logic [16:0]        i_rest,
    output logic               o_valid,
    output t_disc              o_disc
);

    typedef struct packed {
        t_disc       disc;
        logic        tact;
        logic        high;
        logic        uneg;
        logic        sat;
        logic [46:0] rem;
        logic [39:0] num;
    } t_div;

    // Stage A: penetration and approach test, position correction.
    logic signed [33:0] a_pa, a_r, a_tgt;
    logic signed [31:0] a_va;
    logic               a_low, a_high, a_pen, a_contact;
    logic [31:0]        a_avn, a_aw;
    t_disc              a_disc;

    always_comb begin
        a_pa   = FLOOR ? 34'(i_disc.pos_y) : 34'(i_disc.pos_x);
        a_r    = 34'(i_disc.radius);
        a_va   = FLOOR ? i_disc.vel_y : i_disc.vel_x;
        a_low  = (a_pa - a_r) < 34'(i_lo);
        a_high = !a_low && ((a_pa + a_r) > 34'(i_hi));
        a_pen  = !i_disc.asleep && (a_low || a_high);
        a_tgt  = a_low ? (34'(i_lo) + a_r) : (34'(i_hi) - a_r);
        a_contact = a_pen && (a_low ? a_va[31] : ((a_va != '0) && !a_va[31]));
        a_avn  = a_va[31] ? (~a_va + 32'd1) : a_va;
        a_aw   = i_disc.spin[31] ? (~i_disc.spin + 32'd1) : i_disc.spin;
        a_disc = i_disc;
        if (a_pen) begin
            if (FLOOR) begin
                a_disc.pos_y = sat32(64'(a_tgt));
            end else begin
                a_disc.pos_x = sat32(64'(a_tgt));
            end
        end
    end

    logic        r_a_v, r_a_contact, r_a_high, r_a_wneg;
    t_disc       r_a_disc;
    logic [31:0] r_a_avn, r_a_aw;

    // Stage B: normal velocity change and spin contact speed.
    logic [17:0] b_opf;
    logic [49:0] b_dvp;
    logic [62:0] b_rwp;
    always_comb begin
        b_opf = 18'(i_rest) + ONE_Q;
        b_dvp = 50'(b_opf) * 50'(r_a_avn);
        b_rwp = 63'(r_a_disc.radius) * 63'(r_a_aw);
    end

    logic        r_b_v, r_b_contact, r_b_high, r_b_wneg;
    t_disc       r_b_disc;
    logic [32:0] r_b_dv;
    logic [46:0] r_b_rw;

    // Stage C: normal velocity update, impulse, friction bound, tangent speed.
    logic signed [63:0] c_dvs;
    logic signed [31:0] c_va, c_vb;
    logic signed [49:0] c_rws, c_u;
    logic [63:0]        c_impp;
    logic [51:0]        c_dvtp;
    logic               c_kneg;
    t_disc              c_disc;
    always_comb begin
        c_dvs  = 64'(r_b_dv);
        c_va   = FLOOR ? r_b_disc.vel_y : r_b_disc.vel_x;
        c_vb   = FLOOR ? r_b_disc.vel_x : r_b_disc.vel_y;
        c_impp = 64'(r_b_dv) * 64'(r_b_disc.mass);
        c_dvtp = 52'(r_b_dv) * 52'(r_b_disc.friction);
        c_rws  = r_b_wneg ? -50'(r_b_rw) : 50'(r_b_rw);
        c_kneg = r_b_high ^ FLOOR;
        c_u    = 50'(c_vb) - (c_kneg ? -c_rws : c_rws);
        c_disc = r_b_disc;
        if (r_b_contact) begin
            if (FLOOR) begin
                c_disc.vel_y = sat32(64'(c_va) + (r_b_high ? -c_dvs : c_dvs));
            end else begin
                c_disc.vel_x = sat32(64'(c_va) + (r_b_high ? -c_dvs : c_dvs));
            end
        end
    end

    logic               r_c_v, r_c_contact, r_c_high;
    t_disc              r_c_disc;
    logic [47:0]        r_c_imp;
    logic [35:0]        r_c_dvt0;
    logic signed [49:0] r_c_u;

    // Stage D: impulse saturation, friction clamp, contact report.
    logic [48:0] d_au;
    logic [35:0] d_dvt;
    logic [31:0] d_imp;
    t_disc       d_disc;
    always_comb begin
        d_au   = r_c_u[49] ? 49'(-r_c_u) : 49'(r_c_u);
        d_dvt  = (49'(r_c_dvt0) > d_au) ? d_au[35:0] : r_c_dvt0;
        d_imp  = (r_c_imp[47:32] != '0) ? 32'hFFFF_FFFF : r_c_imp[31:0];
        d_disc = r_c_disc;
        if (r_c_contact) begin
            if (FLOOR) begin
                d_disc.floor_hit = r_c_high ? HIT_HIGH : HIT_LOW;
                d_disc.floor_imp = d_imp;
            end else begin
                d_disc.side_hit = r_c_high ? HIT_HIGH : HIT_LOW;
                d_disc.side_imp = d_imp;
            end
        end
    end

    logic        r_d_v, r_d_tact, r_d_high, r_d_uneg;
    t_disc       r_d_disc;
    logic [35:0] r_d_dvt;

    // Stage E: partial products of the spin numerator, tangent velocity update.
    logic [63:0]        e_plo, e_phi;
    logic signed [63:0] e_dvts;
    logic signed [31:0] e_vb;
    t_disc              e_disc;
    always_comb begin
        e_plo  = 64'(r_d_disc.rm) * 64'(r_d_dvt[17:0]);
        e_phi  = 64'(r_d_disc.rm) * 64'(r_d_dvt[35:18]);
        e_dvts = 64'(r_d_dvt);
        e_vb   = FLOOR ? r_d_disc.vel_x : r_d_disc.vel_y;
        e_disc = r_d_disc;
        if (r_d_tact) begin
            if (FLOOR) begin
                e_disc.vel_x = sat32(64'(e_vb) + (r_d_uneg ? e_dvts : -e_dvts));
            end else begin
                e_disc.vel_y = sat32(64'(e_vb) + (r_d_uneg ? e_dvts : -e_dvts));
            end
        end
    end

    logic        r_e_v, r_e_tact, r_e_high, r_e_uneg;
    t_disc       r_e_disc;
    logic [63:0] r_e_plo, r_e_phi;

    // Stage F: numerator sum.
    logic [81:0] f_prod;
    always_comb begin
        f_prod = (82'(r_e_phi) << 18) + 82'(r_e_plo);
    end

    logic        r_f_v, r_f_tact, r_f_high, r_f_uneg;
    t_disc       r_f_disc;
    logic [81:0] r_f_prod;

    // Stage G: overflow test and divider set-up.
    t_div g_div;
    always_comb begin
        g_div.disc = r_f_disc;
        g_div.tact = r_f_tact;
        g_div.high = r_f_high;
        g_div.uneg = r_f_uneg;
        g_div.sat  = (r_f_prod != '0) && (47'(r_f_prod[81:40]) >= r_f_disc.inertia);
        g_div.rem  = 47'(r_f_prod[81:40]);
        g_div.num  = r_f_prod[39:0];
    end

    logic r_g_v;
    t_div r_g;

    // Restoring divider, one quotient bit per stage.
    logic r_q_v [DIV_STEPS];
    t_div r_q   [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div_bit
        t_div        src, nxt;
        logic        src_v;
        logic [47:0] rem2;
        logic        ge;
        if (j == 0) begin : g_first
            assign src   = r_g;
            assign src_v = r_g_v;
        end else begin : g_next
            assign src   = r_q[j-1];
            assign src_v = r_q_v[j-1];
        end
        always_comb begin
            rem2    = {src.rem, src.num[39]};
            ge      = rem2 >= 48'(src.disc.inertia);
            nxt     = src;
            nxt.rem = ge ? 47'(rem2 - 48'(src.disc.inertia)) : rem2[46:0];
            nxt.num = {src.num[38:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[j] <= 1'b0;
            end else if (i_en) begin
                r_q_v[j] <= src_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j] <= nxt;
            end
        end
    end

    // Stage H: spin update. With zero inertia and a zero numerator the change is zero.
    t_div               h_src;
    logic [40:0]        h_dw;
    logic signed [63:0] h_dws;
    logic               h_neg;
    t_disc              h_disc;
    always_comb begin
        h_src  = r_q[DIV_STEPS-1];
        if (h_src.sat) begin
            h_dw = SPIN_CAP;
        end else if (h_src.disc.inertia == '0) begin
            h_dw = '0;
        end else begin
            h_dw = 41'(h_src.num);
        end
        h_dws  = 64'(h_dw);
        h_neg  = h_src.high ^ FLOOR ^ h_src.uneg;
        h_disc = h_src.disc;
        if (h_src.tact) begin
            h_disc.spin = sat32(64'(h_src.disc.spin) + (h_neg ? -h_dws : h_dws));
        end
    end

    logic  r_h_v;
    t_disc r_h_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_q_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_disc    <= a_disc;
            r_a_contact <= a_contact;
            r_a_high    <= a_high;
            r_a_wneg    <= i_disc.spin[31];
            r_a_avn     <= a_avn;
            r_a_aw      <= a_aw;

            r_b_disc    <= r_a_disc;
            r_b_contact <= r_a_contact;
            r_b_high    <= r_a_high;
            r_b_wneg    <= r_a_wneg;
            r_b_dv      <= b_dvp[FRAC_BITS +: 33];
            r_b_rw      <= b_rwp[FRAC_BITS +: 47];

            r_c_disc    <= c_disc;
            r_c_contact <= r_b_contact;
            r_c_high    <= r_b_high;
            r_c_imp     <= c_impp[FRAC_BITS +: 48];
            r_c_dvt0    <= c_dvtp[FRAC_BITS +: 36];
            r_c_u       <= c_u;

            r_d_disc    <= d_disc;
            r_d_tact    <= r_c_contact && (r_c_u != '0);
            r_d_high    <= r_c_high;
            r_d_uneg    <= r_c_u[49];
            r_d_dvt     <= d_dvt;

            r_e_disc    <= e_disc;
            r_e_tact    <= r_d_tact;
            r_e_high    <= r_d_high;
            r_e_uneg    <= r_d_uneg;
            r_e_plo     <= e_plo;
            r_e_phi     <= e_phi;

            r_f_disc    <= r_e_disc;
            r_f_tact    <= r_e_tact;
            r_f_high    <= r_e_high;
            r_f_uneg    <= r_e_uneg;
            r_f_prod    <= f_prod;

            r_g         <= g_div;
            r_h_disc    <= h_disc;
        end
    end

    assign o_valid = r_h_v;
    assign o_disc  = r_h_disc;

endmodule

### rtl/ball_wall_impulse_resolve_top.sv
// Top level of the disc and wall contact block: register port, side and floor pipelines, skid.
// Depends on bwir_pkg, bwir_stream_if, bwir_wall and the assertion macro header.
//
// Channel   Direction  Payload      Handshake
// i_in      sink       t_in_item    valid/ready
// o_out     source     t_out_item   valid/ready
// APB       slave      32-bit regs  psel/penable, pready tied high
//
// One transaction enters per clock while the skid stage is empty.
// The two wall pipelines have 48 stages each, each holding a 40-stage divider.
// Reset is synchronous and active low; it clears the valid bits and the APB registers, not the data registers.
// When the output stalls, one result moves into the skid stage; then the whole pipeline holds.
`timescale 1ns / 1ps
`include "ball_wall_impulse_resolve_top_defines.svh"
module ball_wall_impulse_resolve_top
    import bwir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bwir_stream_if.sink   i_in,
    bwir_stream_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [31:0] r_box_cx, r_box_cy;
    logic [30:0]        r_box_w, r_box_h;
    logic [16:0]        r_rest;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_cx <= '0;
            r_box_cy <= '0;
            r_box_w  <= '0;
            r_box_h  <= '0;
            r_rest   <= RESTITUTION_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_BOX_CX:   r_box_cx <= pwdata;
                REG_BOX_CY:   r_box_cy <= pwdata;
                REG_BOX_W:    r_box_w  <= pwdata[30:0];
                REG_BOX_H:    r_box_h  <= pwdata[30:0];
                REG_WALL_RST: r_rest   <= pwdata[16:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BOX_CX:   prdata = r_box_cx;
            REG_BOX_CY:   prdata = r_box_cy;
            REG_BOX_W:    prdata = 32'(r_box_w);
            REG_BOX_H:    prdata = 32'(r_box_h);
            REG_WALL_RST: prdata = 32'(r_rest);
            default:      prdata = '0;
        endcase
    end

    logic signed [32:0] w_hw, w_hh, w_left, w_right, w_top, w_bottom;
    always_comb begin
        w_hw     = 33'(r_box_w[30:1]);
        w_hh     = 33'(r_box_h[30:1]);
        w_left   = 33'(r_box_cx) - w_hw;
        w_right  = 33'(r_box_cx) + w_hw;
        w_top    = 33'(r_box_cy) - w_hh;
        w_bottom = 33'(r_box_cy) + w_hh;
    end

    logic        r_skid_v;
    t_disc       r_skid;
    logic        w_en;
    logic [61:0] w_rmp;
    t_disc       n_s0;
    logic        r_s0_v;
    t_disc       r_s0;

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    always_comb begin
        w_rmp          = 62'(i_in.payload.radius) * 62'(i_in.payload.mass);
        n_s0.asleep    = i_in.payload.asleep;
        n_s0.pos_x     = i_in.payload.pos_x;
        n_s0.pos_y     = i_in.payload.pos_y;
        n_s0.vel_x     = i_in.payload.vel_x;
        n_s0.vel_y     = i_in.payload.vel_y;
        n_s0.spin      = i_in.payload.spin;
        n_s0.radius    = i_in.payload.radius;
        n_s0.mass      = i_in.payload.mass;
        n_s0.inertia   = i_in.payload.inertia;
        n_s0.friction  = i_in.payload.friction;
        n_s0.rm        = w_rmp[FRAC_BITS +: 46];
        n_s0.side_hit  = HIT_NONE;
        n_s0.side_imp  = '0;
        n_s0.floor_hit = HIT_NONE;
        n_s0.floor_imp = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    logic  w_sd_v, w_fl_v;
    t_disc w_sd_disc, w_fl_disc;

    bwir_wall #(.FLOOR(1'b0)) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_disc  (r_s0),
        .i_lo    (w_left),
        .i_hi    (w_right),
        .i_rest  (r_rest),
        .o_valid (w_sd_v),
        .o_disc  (w_sd_disc)
    );

    bwir_wall #(.FLOOR(1'b1)) u_floor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sd_v),
        .i_disc  (w_sd_disc),
        .i_lo    (w_top),
        .i_hi    (w_bottom),
        .i_rest  (r_rest),
        .o_valid (w_fl_v),
        .o_disc  (w_fl_disc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_fl_v && !o_out.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= w_fl_disc;
        end
    end

    t_disc w_out;
    always_comb begin
        w_out       = r_skid_v ? r_skid : w_fl_disc;
        o_out.valid = r_skid_v || w_fl_v;
        o_out.payload.new_pos_x      = w_out.pos_x;
        o_out.payload.new_pos_y      = w_out.pos_y;
        o_out.payload.new_vel_x      = w_out.vel_x;
        o_out.payload.new_vel_y      = w_out.vel_y;
        o_out.payload.new_spin       = w_out.spin;
        o_out.payload.side_wall_hit  = w_out.side_hit;
        o_out.payload.side_impulse   = w_out.side_imp;
        o_out.payload.floor_wall_hit = w_out.floor_hit;
        o_out.payload.floor_impulse  = w_out.floor_imp;
    end

    `BWIR_ASSERT_IMP(a_side_code, i_clk, i_rst_n, o_out.valid, o_out.payload.side_wall_hit == HIT_NONE || o_out.payload.side_wall_hit == HIT_LOW || o_out.payload.side_wall_hit == HIT_HIGH)
    `BWIR_ASSERT_IMP(a_floor_quiet, i_clk, i_rst_n, o_out.valid && o_out.payload.floor_wall_hit == HIT_NONE, o_out.payload.floor_impulse == '0)
    `BWIR_ASSERT_IMP(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_v), $past(w_fl_v) && !$past(o_out.ready))
    `BWIR_ASSERT_NXT(a_skid_hold, i_clk, i_rst_n, r_skid_v && !o_out.ready, r_skid_v && !i_in.ready)

endmodule
